// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, disabled while reset is high.
`define PLS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pls check failed");
// Clocked check that also holds across reset.
`define PLS_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("pls reset check failed");
`endif

// File: rtl/pls_pkg.sv
// Types and codes shared by the probe latency statistics block.
package pls_pkg;

   localparam logic [1:0] FUNC_SEND   = 2'd0;
   localparam logic [1:0] FUNC_REPLY  = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_LATENCY = 2'd1;
   localparam logic [1:0] KIND_STATS   = 2'd2;
   localparam logic [1:0] KIND_REJECT  = 2'd3;

   localparam logic [10:0] TOTAL_RESET = 11'd100;
   localparam int          LOSS_SCALE  = 10000;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] seq_index;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] seq_number;
      logic [31:0] latency_us;
      logic [10:0] received_count;
      logic [13:0] loss_hundredths;
      logic [31:0] min_us;
      logic [31:0] max_us;
      logic [31:0] mean_us;
      logic [31:0] deviation_us;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/probe_latency_statistics_top.sv
// Probe latency statistics engine: send/reply bookkeeping and statistics pass.
// Send, reject: result the cycle after accept; reply: registered in S_REPLY when rsp_free.
// Statistics: read passes over the table, a restoring divide per quotient, shift-add
// multiplies per valid entry, and an integer square root.
// Sends and rejects: one transaction per cycle while rsp_stall is low; a reply stalls input.
// Synchronous reset, then a clearing pass over all MAX_PACKETS entries before the first item.
module probe_latency_statistics_top #(
   parameter int MAX_PACKETS = 1024,
   parameter int TIME_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pls_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pls_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [10:0]       csr_write_data
);

   localparam int AW  = $clog2(MAX_PACKETS);
   localparam int NW  = $clog2(MAX_PACKETS + 1);
   localparam int TB  = TIME_BITS;
   localparam int DW  = TB + NW;
   localparam int MW  = (DW > 2 * NW) ? DW : 2 * NW;
   localparam int PW  = 2 * MW;
   localparam int ACW = 2 * DW + NW;
   localparam int DSW = 3 * NW;
   localparam int LW  = 14 + NW;
   localparam int DVW = (ACW > LW) ? ACW : LW;
   localparam int DCW = $clog2(DVW + 1);
   localparam int QW  = (2 * TB > 64) ? 64 : 2 * TB;
   localparam int SCW = $clog2(QW / 2 + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_REPLY, S_INIT, S_P1, S_P2_RD, S_P2_WAIT,
      S_MUL, S_DIV, S_SQRT, S_LOSS, S_OUT
   } state_type;

   typedef enum logic [1:0] {MUL_NL, MUL_DD, MUL_NN, MUL_NNT} mul_op_type;
   typedef enum logic [1:0] {DIV_MEAN, DIV_DEV, DIV_LOSS} div_op_type;

   logic [TB-1:0] send_mem [MAX_PACKETS];
   logic [TB:0]   lat_mem  [MAX_PACKETS];

   logic          send_we, send_re, lat_we, lat_re;
   logic [AW-1:0] send_wa, send_ra, lat_wa, lat_ra;
   logic [TB-1:0] send_wd, send_rd_ff;
   logic [TB:0]   lat_wd, lat_rd_ff;

   state_type        state_ff, state_in;
   mul_op_type       mul_op_ff, mul_op_in;
   div_op_type       div_op_ff, div_op_in;
   logic [NW-1:0]    cnt_ff, cnt_in, nseq_ff, nseq_in, n_ff, n_in;
   logic             pend_ff, pend_in, first_ff, first_in;
   logic [10:0]      csr_ff, csr_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [TB-1:0]    now_ff, now_in, mn_ff, mn_in, mx_ff, mx_in;
   logic [DW-1:0]    sum_ff, sum_in;
   logic [31:0]      mean_ff, mean_in, dev_ff, dev_in;
   logic [13:0]      loss_ff, loss_in;
   logic [ACW-1:0]   acc_ff, acc_in;
   logic [PW-1:0]    mul_a_ff, mul_a_in, prod_ff, prod_in;
   logic [MW-1:0]    mul_b_ff, mul_b_in;
   logic [DSW-1:0]   div_rem_ff, div_rem_in, div_dsr_ff, div_dsr_in;
   logic [DVW-1:0]   div_dq_ff, div_dq_in;
   logic [DCW-1:0]   div_cnt_ff, div_cnt_in;
   logic [QW-1:0]    sq_x_ff, sq_x_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [SCW-1:0]   sq_cnt_ff, sq_cnt_in;
   pls_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (send_we) begin
         send_mem[send_wa] <= send_wd;
      end
      if (send_re) begin
         send_rd_ff <= send_mem[send_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (lat_we) begin
         lat_mem[lat_wa] <= lat_wd;
      end
      if (lat_re) begin
         lat_rd_ff <= lat_mem[lat_ra];
      end
   end

   always_comb begin
      logic [NW-1:0]  t_eff;
      logic           rsp_free;
      logic           accept;
      logic [TB-1:0]  lat;
      logic [DSW:0]   rem_sh;
      logic           ge;
      logic [DVW-1:0] quot;
      logic [DW-1:0]  nl;
      logic [DW-1:0]  d_val;
      logic [QW-1:0]  trial;
      logic [QW-1:0]  res_nx;
      logic [LW-1:0]  loss_dvd;

      if (32'(csr_ff) > 32'(MAX_PACKETS)) begin
         t_eff = NW'(MAX_PACKETS);
      end else if (csr_ff == 11'd0) begin
         t_eff = NW'(1);
      end else begin
         t_eff = NW'(csr_ff);
      end

      rsp_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = !(state_ff == S_IDLE && rsp_free);
      accept    = req_valid && !req_stall;
      lat       = TB'(now_ff - send_rd_ff);

      rem_sh = {div_rem_ff, div_dq_ff[DVW-1]};
      ge     = rem_sh >= {1'b0, div_dsr_ff};
      quot   = {div_dq_ff[DVW-2:0], ge};

      nl    = DW'(prod_ff);
      d_val = (nl >= sum_ff) ? nl - sum_ff : sum_ff - nl;

      trial  = sq_res_ff + sq_bit_ff;
      res_nx = (sq_x_ff >= trial) ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;

      loss_dvd = LW'(pls_pkg::LOSS_SCALE) * LW'(t_eff - n_ff);

      state_in     = state_ff;
      mul_op_in    = mul_op_ff;
      div_op_in    = div_op_ff;
      cnt_in       = cnt_ff;
      nseq_in      = nseq_ff;
      n_in         = n_ff;
      pend_in      = 1'b0;
      first_in     = first_ff;
      csr_in       = csr_write_enable ? csr_write_data : csr_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      loss_in      = loss_ff;
      acc_in       = acc_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      prod_in      = prod_ff;
      div_rem_in   = div_rem_ff;
      div_dsr_in   = div_dsr_ff;
      div_dq_in    = div_dq_ff;
      div_cnt_in   = div_cnt_ff;
      sq_x_in      = sq_x_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      sq_cnt_in    = sq_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      send_we = 1'b0;
      send_wa = nseq_ff[AW-1:0];
      send_wd = TB'(req_data.time_us);
      send_re = 1'b0;
      send_ra = AW'(req_data.seq_index);
      lat_we  = 1'b0;
      lat_wa  = idx_ff;
      lat_wd  = {1'b1, lat};
      lat_re  = 1'b0;
      lat_ra  = cnt_ff[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            lat_we = 1'b1;
            lat_wa = cnt_ff[AW-1:0];
            lat_wd = '0;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(MAX_PACKETS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_in      = '0;
               rsp_in.kind = pls_pkg::KIND_REJECT;
               rsp_in.last = 1'b1;
               case (req_data.func)
                  pls_pkg::FUNC_SEND: begin
                     rsp_valid_in = 1'b1;
                     if (nseq_ff < t_eff) begin
                        send_we           = 1'b1;
                        rsp_in.kind       = pls_pkg::KIND_ACK;
                        rsp_in.seq_number = 12'(nseq_ff);
                        nseq_in           = nseq_ff + NW'(1);
                     end
                  end
                  pls_pkg::FUNC_REPLY: begin
                     if (32'(req_data.seq_index) < 32'(t_eff)) begin
                        send_re  = 1'b1;
                        idx_in   = AW'(req_data.seq_index);
                        now_in   = TB'(req_data.time_us);
                        state_in = S_REPLY;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pls_pkg::FUNC_FINISH: begin
                     state_in = S_INIT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               lat_we            = 1'b1;
               rsp_in            = '0;
               rsp_in.kind       = pls_pkg::KIND_LATENCY;
               rsp_in.seq_number = 12'(idx_ff);
               rsp_in.latency_us = 32'(lat);
               rsp_valid_in      = 1'b1;
               if (NW'(idx_ff) + NW'(1) == t_eff) begin
                  state_in = S_INIT;
               end else begin
                  rsp_in.last = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_INIT: begin
            n_in     = '0;
            sum_in   = '0;
            mn_in    = '0;
            mx_in    = '0;
            mean_in  = '0;
            dev_in   = '0;
            first_in = 1'b1;
            cnt_in   = '0;
            state_in = S_P1;
         end
         S_P1: begin
            if (cnt_ff < t_eff) begin
               lat_re  = 1'b1;
               cnt_in  = cnt_ff + NW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && lat_rd_ff[TB]) begin
               n_in     = n_ff + NW'(1);
               sum_in   = sum_ff + DW'(lat_rd_ff[TB-1:0]);
               first_in = 1'b0;
               if (first_ff || lat_rd_ff[TB-1:0] < mn_ff) begin
                  mn_in = lat_rd_ff[TB-1:0];
               end
               if (first_ff || lat_rd_ff[TB-1:0] > mx_ff) begin
                  mx_in = lat_rd_ff[TB-1:0];
               end
            end
            if (cnt_ff >= t_eff && !pend_ff) begin
               if (n_ff == '0) begin
                  state_in = S_LOSS;
               end else begin
                  div_dq_in  = DVW'(sum_ff);
                  div_dsr_in = DSW'(n_ff);
                  div_rem_in = '0;
                  div_cnt_in = '0;
                  div_op_in  = DIV_MEAN;
                  state_in   = S_DIV;
               end
            end
         end
         S_P2_RD: begin
            if (cnt_ff < t_eff) begin
               lat_re   = 1'b1;
               cnt_in   = cnt_ff + NW'(1);
               state_in = S_P2_WAIT;
            end else begin
               mul_a_in  = PW'(n_ff);
               mul_b_in  = MW'(n_ff);
               prod_in   = '0;
               mul_op_in = MUL_NN;
               state_in  = S_MUL;
            end
         end
         S_P2_WAIT: begin
            if (lat_rd_ff[TB]) begin
               mul_a_in  = PW'(lat_rd_ff[TB-1:0]);
               mul_b_in  = MW'(n_ff);
               prod_in   = '0;
               mul_op_in = MUL_NL;
               state_in  = S_MUL;
            end else begin
               state_in = S_P2_RD;
            end
         end
         S_MUL: begin
            if (mul_b_ff == '0) begin
               case (mul_op_ff)
                  MUL_NL: begin
                     mul_a_in  = PW'(d_val);
                     mul_b_in  = MW'(d_val);
                     prod_in   = '0;
                     mul_op_in = MUL_DD;
                  end
                  MUL_DD: begin
                     acc_in   = acc_ff + ACW'(prod_ff);
                     state_in = S_P2_RD;
                  end
                  MUL_NN: begin
                     mul_a_in  = prod_ff;
                     mul_b_in  = MW'(t_eff);
                     prod_in   = '0;
                     mul_op_in = MUL_NNT;
                  end
                  default: begin
                     div_dq_in  = DVW'(acc_ff);
                     div_dsr_in = DSW'(prod_ff);
                     div_rem_in = '0;
                     div_cnt_in = '0;
                     div_op_in  = DIV_DEV;
                     state_in   = S_DIV;
                  end
               endcase
            end else begin
               if (mul_b_ff[0]) begin
                  prod_in = prod_ff + mul_a_ff;
               end
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end
         end
         S_DIV: begin
            div_rem_in = ge ? DSW'(rem_sh - {1'b0, div_dsr_ff}) : DSW'(rem_sh);
            div_dq_in  = quot;
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(DVW - 1)) begin
               case (div_op_ff)
                  DIV_MEAN: begin
                     mean_in  = 32'(quot);
                     acc_in   = '0;
                     cnt_in   = '0;
                     state_in = S_P2_RD;
                  end
                  DIV_DEV: begin
                     sq_x_in   = QW'(quot);
                     sq_res_in = '0;
                     sq_bit_in = QW'(1) << (QW - 2);
                     sq_cnt_in = '0;
                     state_in  = S_SQRT;
                  end
                  default: begin
                     loss_in  = 14'(quot);
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_SQRT: begin
            if (sq_x_ff >= trial) begin
               sq_x_in = sq_x_ff - trial;
            end
            sq_res_in = res_nx;
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + SCW'(1);
            if (sq_cnt_ff == SCW'(QW / 2 - 1)) begin
               dev_in   = 32'(res_nx);
               state_in = S_LOSS;
            end
         end
         S_LOSS: begin
            div_dq_in  = DVW'(loss_dvd);
            div_dsr_in = DSW'(t_eff);
            div_rem_in = '0;
            div_cnt_in = '0;
            div_op_in  = DIV_LOSS;
            state_in   = S_DIV;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_in                 = '0;
               rsp_in.kind            = pls_pkg::KIND_STATS;
               rsp_in.received_count  = 11'(n_ff);
               rsp_in.loss_hundredths = loss_ff;
               rsp_in.min_us          = 32'(mn_ff);
               rsp_in.max_us          = 32'(mx_ff);
               rsp_in.mean_us         = mean_ff;
               rsp_in.deviation_us    = dev_ff;
               rsp_in.last            = 1'b1;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         nseq_ff      <= '0;
         pend_ff      <= 1'b0;
         csr_ff       <= pls_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nseq_ff      <= nseq_in;
         pend_ff      <= pend_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_op_ff  <= mul_op_in;
      div_op_ff  <= div_op_in;
      n_ff       <= n_in;
      first_ff   <= first_in;
      idx_ff     <= idx_in;
      now_ff     <= now_in;
      mn_ff      <= mn_in;
      mx_ff      <= mx_in;
      sum_ff     <= sum_in;
      mean_ff    <= mean_in;
      dev_ff     <= dev_in;
      loss_ff    <= loss_in;
      acc_ff     <= acc_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      prod_ff    <= prod_in;
      div_rem_ff <= div_rem_in;
      div_dsr_ff <= div_dsr_in;
      div_dq_ff  <= div_dq_in;
      div_cnt_ff <= div_cnt_in;
      sq_x_ff    <= sq_x_in;
      sq_res_ff  <= sq_res_in;
      sq_bit_ff  <= sq_bit_in;
      sq_cnt_ff  <= sq_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/pls_checker.sv
// Port-level checks for the probe latency statistics block, bound to the top level.
`include "assert_macros.svh"

module pls_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pls_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pls_pkg::rsp_type rsp_data
);

   `PLS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `PLS_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid)
   `PLS_ASSERT(a_send_answer, req_valid && !req_stall && req_data.func == pls_pkg::FUNC_SEND |=> rsp_valid && (rsp_data.kind == pls_pkg::KIND_ACK || rsp_data.kind == pls_pkg::KIND_REJECT))
   `PLS_ASSERT(a_stats_last, rsp_valid && rsp_data.kind == pls_pkg::KIND_STATS |-> rsp_data.last)
   `PLS_ASSERT(a_reject_clean, rsp_valid && rsp_data.kind == pls_pkg::KIND_REJECT |-> rsp_data.last && rsp_data.seq_number == 12'd0 && rsp_data.latency_us == 32'd0)

endmodule

bind probe_latency_statistics_top pls_checker u_pls_checker (.*);
